@@ rtl/core/assembly_line_lexer_checker_macros.svh @@
// ---------------------------------------------------------------------------
// assembly_line_lexer_checker_macros
// assertion helpers for the lexer/checker block
// ---------------------------------------------------------------------------
`ifndef ASSEMBLY_LINE_LEXER_CHECKER_MACROS_SVH
`define ASSEMBLY_LINE_LEXER_CHECKER_MACROS_SVH

// implication checked on every clock edge outside reset
`define ALC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication outside reset
`define ALC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/alc_pkg.sv @@
// ---------------------------------------------------------------------------
// alc_pkg
// types, codes and keyword tables shared by the lexer/checker modules
// ---------------------------------------------------------------------------
package alc_pkg;

    localparam int LINE_WIDTH_DEF = 16;
    localparam logic [15:0] ADDR_LIMIT_RESET = 16'd1024;
    localparam int NKEYS = 24;
    localparam int NDIRS = 5;

    localparam logic [2:0] CL_DIR   = 3'd0;
    localparam logic [2:0] CL_LABEL = 3'd1;
    localparam logic [2:0] CL_HEX   = 3'd2;
    localparam logic [2:0] CL_DEC   = 3'd3;
    localparam logic [2:0] CL_INS   = 3'd4;
    localparam logic [2:0] CL_NAME  = 3'd5;

    localparam logic [2:0] FIRST_LABEL = 3'd5;
    localparam logic [2:0] FIRST_NAME  = 3'd6;
    localparam logic [2:0] FIRST_OTHER = 3'd7;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_LEX  = 2'd1;
    localparam logic [1:0] ERR_GRAM = 2'd2;

    localparam logic       KIND_TOKEN   = 1'b0;
    localparam logic       KIND_VERDICT = 1'b1;

    // queue entry from front to back: one classified byte event
    typedef struct packed {
        logic       tok;       // a word ended
        logic       tok_ok;
        logic [2:0] tok_cls;
        logic [2:0] dir_id;
        logic [15:0] value;
        logic       eol;
    } alc_evt_t;

    // keyword characters, 7 per keyword, zero padded
    function automatic logic [7:0] key_char(input logic [4:0] k, input logic [2:0] i);
        logic [55:0] s;
        unique case (k)
            5'd0:  s = {".set", 24'h0};
            5'd1:  s = {".org", 24'h0};
            5'd2:  s = {".align", 8'h0};
            5'd3:  s = {".wfill", 8'h0};
            5'd4:  s = {".word", 16'h0};
            5'd5:  s = {"ld", 40'h0};
            5'd6:  s = {"ldinv", 16'h0};
            5'd7:  s = {"ldabs", 16'h0};
            5'd8:  s = {"ldmq", 24'h0};
            5'd9:  s = {"ldmqmx", 8'h0};
            5'd10: s = {"store", 16'h0};
            5'd11: s = {"jump", 24'h0};
            5'd12: s = {"jumpl", 16'h0};
            5'd13: s = {"jumpr", 16'h0};
            5'd14: s = {"add", 32'h0};
            5'd15: s = {"addabs", 8'h0};
            5'd16: s = {"sub", 32'h0};
            5'd17: s = {"subabs", 8'h0};
            5'd18: s = {"mult", 24'h0};
            5'd19: s = {"div", 32'h0};
            5'd20: s = {"lsh", 32'h0};
            5'd21: s = {"rsh", 32'h0};
            5'd22: s = {"storal", 8'h0};
            5'd23: s = {"storar", 8'h0};
            default: s = 56'h0;
        endcase
        return s[55 - 8*i -: 8];
    endfunction

    function automatic logic [3:0] key_len(input logic [4:0] k);
        logic [3:0] n;
        n = 4'd7;
        for (int i = 6; i >= 0; i--) begin
            if (key_char(k, 3'(i)) == 8'h0) n = 4'(i);
        end
        return n;
    endfunction

endpackage

@@ rtl/core/alc_front.sv @@
// ---------------------------------------------------------------------------
// alc_front
// scans bytes, builds words and classifies each word when it ends
// ---------------------------------------------------------------------------
module alc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic [7:0]            text_char,
    output logic                  evt_push,
    output alc_pkg::alc_evt_t     evt
);
    import alc_pkg::*;

    localparam logic [1:0] MODE_BETWEEN = 2'd0;
    localparam logic [1:0] MODE_WORD    = 2'd1;
    localparam logic [1:0] MODE_COMMENT = 2'd2;

    localparam int SF_DOT = 0, SF_DIG0 = 1, SF_ALLDIG = 2, SF_HEXPRE = 3;
    localparam int SF_HEXTAIL = 4, SF_PREVOK = 5, SF_LASTOK = 6, SF_COLON = 7;

    logic [1:0]        mode_reg, mode_next;
    logic [3:0]        len_reg, len_next;
    logic [7:0]        flags_reg, flags_next;
    logic [NKEYS-1:0]  cand_reg, cand_next;
    logic [15:0]       value_reg, value_next;

    logic [7:0] c;
    logic       eol, sep, dig, namec, hexd;
    logic [3:0] dval, hval;
    logic [19:0] mul10, mul16;
    logic [4:0]  dir_hit;
    logic        ins_hit;

    always_comb
    begin
        c = (text_char >= 8'h41 && text_char <= 8'h5a) ? text_char + 8'd32 : text_char;
        eol = (c == 8'h0a) || (c == 8'h00);
        sep = eol || c == 8'h20 || c == 8'h09;
        dig = c >= "0" && c <= "9";
        namec = (c >= "a" && c <= "z") || dig || c == "_";
        dval = c[3:0];
        hexd = dig || (c >= "a" && c <= "f");
        hval = dig ? c[3:0] : c[3:0] + 4'd9;
    end

    // byte absorb: comment skip, word build and word or line end events
    always_comb
    begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        flags_next = flags_reg;
        cand_next  = cand_reg;
        value_next = value_reg;
        mul10 = {4'd0, value_reg} * 20'd10 + {16'd0, dval};
        mul16 = {value_reg, 4'd0} + {16'd0, hval};
        evt_push = 1'b0;
        if (in_fire) begin
            if (mode_reg == MODE_COMMENT) begin
                if (eol) begin
                    mode_next = MODE_BETWEEN;
                    evt_push = 1'b1;
                end
            end else if (!sep) begin
                if (mode_reg == MODE_BETWEEN && c == "#") begin
                    mode_next = MODE_COMMENT;
                end else begin
                    mode_next = MODE_WORD;
                    if (len_reg == 4'd0) begin
                        flags_next = 8'h0;
                        flags_next[SF_HEXTAIL] = 1'b1;
                        flags_next[SF_PREVOK] = 1'b1;
                        flags_next[SF_DOT] = c == ".";
                        flags_next[SF_DIG0] = dig;
                        flags_next[SF_ALLDIG] = dig;
                        value_next = dig ? {12'd0, dval} : 16'd0;
                        cand_next = '1;
                    end else begin
                        if (!flags_reg[SF_LASTOK]) flags_next[SF_PREVOK] = 1'b0;
                        if (len_reg == 4'd1) begin
                            if (flags_reg[SF_ALLDIG] && value_reg == 16'd0 && c == "x")
                                flags_next[SF_HEXPRE] = 1'b1;
                        end else if (flags_reg[SF_HEXPRE]) begin
                            if (hexd)
                                value_next = (mul16[19:16] != 4'd0) ? 16'hffff : mul16[15:0];
                            else
                                flags_next[SF_HEXTAIL] = 1'b0;
                        end
                        if (!dig) flags_next[SF_ALLDIG] = 1'b0;
                        else if (flags_reg[SF_ALLDIG])
                            value_next = (mul10[19:16] != 4'd0) ? 16'hffff : mul10[15:0];
                    end
                    flags_next[SF_LASTOK] = namec;
                    flags_next[SF_COLON] = c == ":";
                    for (int k = 0; k < NKEYS; k++) begin
                        if (len_reg >= key_len(5'(k)) || len_reg > 4'd6
                            || key_char(5'(k), len_reg[2:0]) != c)
                            cand_next[k] = 1'b0;
                    end
                    len_next = (len_reg < 4'd15) ? len_reg + 4'd1 : 4'd15;
                end
            end else begin
                if (mode_reg == MODE_WORD) begin
                    len_next = 4'd0;
                    flags_next = 8'h0;
                    cand_next = '0;
                    value_next = 16'd0;
                end
                mode_next = MODE_BETWEEN;
                evt_push = (mode_reg == MODE_WORD) || eol;
            end
        end
    end

    // classification of the word in progress
    always_comb
    begin
        dir_hit = 5'h1f;
        for (int k = NDIRS - 1; k >= 0; k--) begin
            if (cand_reg[k] && key_len(5'(k)) == len_reg) dir_hit = 5'(k);
        end
        ins_hit = 1'b0;
        for (int k = NDIRS; k < NKEYS; k++) begin
            if (cand_reg[k] && key_len(5'(k)) == len_reg) ins_hit = 1'b1;
        end
        evt.tok = mode_reg == MODE_WORD;
        evt.eol = eol;
        evt.value = value_reg;
        evt.dir_id = dir_hit[2:0];
        evt.tok_cls = CL_NAME;
        evt.tok_ok = flags_reg[SF_PREVOK] && flags_reg[SF_LASTOK] && !flags_reg[SF_DIG0];
        priority if (flags_reg[SF_DOT]) begin
            evt.tok_cls = CL_DIR;
            evt.tok_ok = dir_hit != 5'h1f;
        end else if (flags_reg[SF_COLON]) begin
            evt.tok_cls = CL_LABEL;
            evt.tok_ok = !flags_reg[SF_DIG0] && flags_reg[SF_PREVOK];
        end else if (flags_reg[SF_HEXPRE]) begin
            evt.tok_cls = CL_HEX;
            evt.tok_ok = flags_reg[SF_HEXTAIL];
        end else if (flags_reg[SF_ALLDIG]) begin
            evt.tok_cls = CL_DEC;
            evt.tok_ok = 1'b1;
        end else if (ins_hit) begin
            evt.tok_cls = CL_INS;
            evt.tok_ok = 1'b1;
        end else begin
            evt.tok_cls = CL_NAME;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_BETWEEN;
            len_reg   <= 4'd0;
            flags_reg <= 8'h0;
            cand_reg  <= '0;
            value_reg <= 16'd0;
        end else begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            flags_reg <= flags_next;
            cand_reg  <= cand_next;
            value_reg <= value_next;
        end
    end

endmodule

@@ rtl/core/alc_back.sv @@
// ---------------------------------------------------------------------------
// alc_back
// line bookkeeping, line verdicts and the result output register
// ---------------------------------------------------------------------------
module alc_back #(
    parameter int LINE_WIDTH = alc_pkg::LINE_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  evt_valid,
    input  alc_pkg::alc_evt_t     evt,
    output logic                  evt_pop,
    input  logic [15:0]           address_limit,
    output logic                  halted,
    output logic                  valid,
    input  logic                  stall,
    output logic                  result_kind,
    output logic [2:0]            token_class,
    output logic [15:0]           line_number,
    output logic [1:0]            error_code,
    output logic                  last
);
    import alc_pkg::*;

    logic [LINE_WIDTH-1:0] line_reg;
    logic [2:0] cnt_reg, first_reg, t1_reg, t2_reg;
    logic       below_reg, later_reg, halt_reg;
    logic       phase_reg;      // token of this event already sent
    logic       ov_reg;
    logic       kind_reg, last_reg;
    logic [2:0] cls_reg;
    logic [1:0] err_reg;
    logic [15:0] ln_reg;

    logic       out_free, send, send_tok, tok_bad, bad, t1dec, done;
    logic [2:0] cnt_after, first_after, t1_after, t2_after;
    logic       below_after, later_after;
    logic [15:0] ln_now;

    function automatic logic isnum(input logic [2:0] k);
        return k == CL_DEC || k == CL_HEX;
    endfunction

    always_comb
    begin
        ln_now = (LINE_WIDTH > 16 && (line_reg >> 16) != '0) ? 16'hffff : 16'(line_reg);
        out_free = !ov_reg || !stall;
        send = evt_valid && out_free && !halt_reg;
        send_tok = evt.tok && !phase_reg;
        tok_bad = send_tok && !evt.tok_ok;
        cnt_after = cnt_reg;
        first_after = first_reg;
        t1_after = t1_reg;
        t2_after = t2_reg;
        below_after = below_reg;
        later_after = later_reg;
        if (send_tok && evt.tok_ok) begin
            if (cnt_reg == 3'd0) begin
                if (evt.tok_cls == CL_DIR) first_after = evt.dir_id;
                else if (evt.tok_cls == CL_LABEL) first_after = FIRST_LABEL;
                else if (evt.tok_cls == CL_NAME) first_after = FIRST_NAME;
                else first_after = FIRST_OTHER;
            end else begin
                if (cnt_reg == 3'd1) begin
                    t1_after = evt.tok_cls;
                    below_after = isnum(evt.tok_cls) && evt.value < address_limit;
                end else if (cnt_reg == 3'd2) begin
                    t2_after = evt.tok_cls;
                end
                if (evt.tok_cls == CL_LABEL) later_after = 1'b1;
            end
            if (cnt_reg != 3'd7) cnt_after = cnt_reg + 3'd1;
        end
        t1dec = t1_after == CL_DEC && below_after;
        bad = 1'b0;
        if (cnt_after != 3'd0) begin
            unique case (first_after)
                3'd0: bad = cnt_after != 3'd3 || t1_after != CL_NAME || !isnum(t2_after);
                3'd1: bad = cnt_after != 3'd2 || !below_after;
                3'd2: bad = cnt_after != 3'd2 || !t1dec;
                3'd3: bad = cnt_after != 3'd3 || !t1dec
                            || !(isnum(t2_after) || t2_after == CL_NAME);
                3'd4: bad = cnt_after != 3'd2 || !(isnum(t1_after) || t1_after == CL_NAME);
                FIRST_LABEL: bad = later_after;
                FIRST_NAME: bad = 1'b1;
                default: bad = 1'b0;
            endcase
        end
        // a token and a verdict from one event are sent as two items: token first
        done = send && !(send_tok && evt.eol && evt.tok_ok);
        evt_pop = (evt_valid && halt_reg) || done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_reg  <= LINE_WIDTH'(1);
            cnt_reg   <= 3'd0;
            first_reg <= 3'd0;
            t1_reg    <= 3'd0;
            t2_reg    <= 3'd0;
            below_reg <= 1'b0;
            later_reg <= 1'b0;
            halt_reg  <= 1'b0;
            phase_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            if (out_free) ov_reg <= send;
            if (send) begin
                if (send_tok) begin
                    phase_reg <= !done;
                    if (!evt.tok_ok) halt_reg <= 1'b1;
                    cnt_reg <= cnt_after;
                    first_reg <= first_after;
                    t1_reg <= t1_after;
                    t2_reg <= t2_after;
                    below_reg <= below_after;
                    later_reg <= later_after;
                end else begin
                    phase_reg <= 1'b0;
                    if (bad) halt_reg <= 1'b1;
                    cnt_reg <= 3'd0;
                    first_reg <= 3'd0;
                    t1_reg <= 3'd0;
                    t2_reg <= 3'd0;
                    below_reg <= 1'b0;
                    later_reg <= 1'b0;
                    if (line_reg != '1) line_reg <= line_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (send) begin
            ln_reg <= ln_now;
            if (send_tok) begin
                kind_reg <= KIND_TOKEN;
                cls_reg <= evt.tok_ok ? evt.tok_cls : CL_DIR;
                err_reg <= evt.tok_ok ? ERR_NONE : ERR_LEX;
                last_reg <= tok_bad || !evt.eol;
            end else begin
                kind_reg <= KIND_VERDICT;
                cls_reg <= CL_DIR;
                err_reg <= bad ? ERR_GRAM : ERR_NONE;
                last_reg <= 1'b1;
            end
        end
    end

    assign halted = halt_reg;
    assign valid = ov_reg;
    assign result_kind = kind_reg;
    assign token_class = cls_reg;
    assign line_number = ln_reg;
    assign error_code = err_reg;
    assign last = last_reg;

    `include "assembly_line_lexer_checker_macros.svh"
    `ALC_ASSERT_NEXT(a_err_halts, clk, rst_n, send && (tok_bad || (!send_tok && bad)), halt_reg)
    `ALC_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halt_reg, halt_reg)
    `ALC_ASSERT_NEXT(a_no_send_halted, clk, rst_n, halt_reg && !ov_reg, !ov_reg)
    `ALC_ASSERT_IMP(a_split_only_eol, clk, rst_n, phase_reg, evt_valid && evt.eol)

endmodule

@@ rtl/core/assembly_line_lexer_checker.sv @@
// ---------------------------------------------------------------------------
// assembly_line_lexer_checker
// byte-serial assembly lexer with per-line grammar check
// ---------------------------------------------------------------------------
// input channel: text_char with valid/stall, one byte per cycle unless stalled.
// output channel: result items (token class or line verdict) with valid/stall.
// a byte that ends a word gives a token item; a line end gives a verdict item,
// so one byte gives up to two items, the one carrying last closes that byte.
// the front classifies in the accept cycle and pushes an event into a
// 2-entry queue; the back takes the event from the queue and registers
// the item in its output register, which drives output valid.
// a word ending on a line end gives two items from one event; bytes inside a
// word give no event, so the input takes one byte per cycle while not stalled.
// input stall rises only when the queue holds two events, so a stalled
// receiver backs up to the input once two more word or line ends arrive.
// any lexical or grammar error halts: later bytes are taken and dropped.
// reset clears line count to 1, scanner state and halt; address_limit -> 1024.
// address_limit is written over the apb port at address 0.
// ---------------------------------------------------------------------------
module assembly_line_lexer_checker #(
    parameter int LINE_WIDTH = alc_pkg::LINE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [2:0]  token_class,
    output logic [15:0] line_number,
    output logic [1:0]  error_code,
    output logic        last
);
    import alc_pkg::*;

    logic [15:0] limit_reg;
    logic        in_fire, evt_push, evt_pop, halted;
    alc_evt_t    evt_in, q_reg [2];
    logic [1:0]  cnt_reg;
    logic        rd_reg, wr_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) limit_reg <= ADDR_LIMIT_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0) limit_reg <= pwdata[15:0];
    end

    assign in_stall = cnt_reg == 2'd2;
    assign in_fire = in_valid && !in_stall;

    alc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .text_char(text_char),
        .evt_push(evt_push), .evt(evt_in)
    );

    // two-entry event queue between front and back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end else begin
            if (evt_push) wr_reg <= !wr_reg;
            if (evt_pop) rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, evt_push} - {1'b0, evt_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_push) q_reg[wr_reg] <= evt_in;
    end

    alc_back #(.LINE_WIDTH(LINE_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .evt_valid(cnt_reg != 2'd0), .evt(q_reg[rd_reg]),
        .evt_pop(evt_pop), .address_limit(limit_reg), .halted(halted),
        .valid(out_valid), .stall(out_stall), .result_kind(result_kind),
        .token_class(token_class), .line_number(line_number),
        .error_code(error_code), .last(last)
    );

    `include "assembly_line_lexer_checker_macros.svh"
    `ALC_ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, cnt_reg != 2'd3)
    `ALC_ASSERT_IMP(a_no_push_full, clk, rst_n, cnt_reg == 2'd2, !evt_push)
    `ALC_ASSERT_NEXT(a_halted_quiet, clk, rst_n, halted && !out_valid, !out_valid)

endmodule

@@ tb/tb_assembly_line_lexer_checker.sv @@
// ---------------------------------------------------------------------------
// tb_assembly_line_lexer_checker
// self-checking bench for the byte-serial assembly lexer and line checker
// ---------------------------------------------------------------------------
// source lines are generated as text, fed one byte per item through the
// valid/stall input, and every result item is compared with a local
// lexer model. address_limit is rewritten between phases while idle. the
// run ends with one faulty line, after which the block must stay silent.
// ---------------------------------------------------------------------------
module tb_assembly_line_lexer_checker;
    import alc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;

    localparam bit [7:0] SH_DOT     = 8'h01;
    localparam bit [7:0] SH_DIG0    = 8'h02;
    localparam bit [7:0] SH_ALLDIG  = 8'h04;
    localparam bit [7:0] SH_HEXPRE  = 8'h08;
    localparam bit [7:0] SH_HEXTAIL = 8'h10;
    localparam bit [7:0] SH_PREVOK  = 8'h20;
    localparam bit [7:0] SH_LASTOK  = 8'h40;
    localparam bit [7:0] SH_COLON   = 8'h80;

    typedef enum bit [1:0] {SCAN_GAP, SCAN_WORD, SCAN_NOTE} scan_t;

    typedef struct {
        bit        kind;
        bit [2:0]  cls;
        bit [15:0] line;
        bit [1:0]  err;
        bit        last;
    } lex_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  text_char = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        result_kind;
    logic [2:0]  token_class;
    logic [15:0] line_number;
    logic [1:0]  error_code;
    logic        last;

    assembly_line_lexer_checker u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .text_char(text_char),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .token_class(token_class),
        .line_number(line_number), .error_code(error_code), .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------ lexer model
    string       kw_text[24] = '{".set", ".org", ".align", ".wfill", ".word",
        "ld", "ldinv", "ldabs", "ldmq", "ldmqmx", "store", "jump",
        "jumpl", "jumpr", "add", "addabs", "sub", "subabs", "mult",
        "div", "lsh", "rsh", "storal", "storar"};

    bit [15:0]   limit_reg;
    int unsigned src_line;
    scan_t       scan;
    bit          stopped;
    int unsigned wlen;
    bit [7:0]    shape;
    bit [23:0]   cand;
    int unsigned wval;
    int unsigned ln_cnt;
    bit [2:0]    ln_first;
    bit [2:0]    ln_t1_cls;
    bit          ln_t1_below;
    bit [2:0]    ln_t2_cls;
    bit          ln_later_label;

    lex_result_t pending_results[$];

    function automatic bit is_dig(bit [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_char(bit [7:0] c);
        return (c >= "a" && c <= "z") || is_dig(c) || c == "_";
    endfunction

    function automatic int unsigned sat16(int unsigned v);
        return v > 65535 ? 65535 : v;
    endfunction

    function automatic void clear_line();
        ln_cnt = 0; ln_first = 0; ln_t1_cls = 0; ln_t1_below = 0;
        ln_t2_cls = 0; ln_later_label = 0;
    endfunction

    function automatic void take_char(bit [7:0] c);
        int unsigned idx;
        bit [7:0] f;
        int unsigned h;
        idx = wlen;
        f = shape;
        if (idx == 0)
        begin
            f = SH_HEXTAIL | SH_PREVOK;
            if (c == ".") f |= SH_DOT;
            if (is_dig(c)) f |= SH_DIG0 | SH_ALLDIG;
            wval = is_dig(c) ? c - "0" : 0;
            cand = '1;
        end
        else
        begin
            if ((f & SH_LASTOK) == 0) f &= ~SH_PREVOK;
            if (idx == 1)
            begin
                if ((f & SH_ALLDIG) != 0 && wval == 0 && c == "x") f |= SH_HEXPRE;
            end
            else if ((f & SH_HEXPRE) != 0)
            begin
                h = 16;
                if (is_dig(c)) h = c - "0";
                else if (c >= "a" && c <= "f") h = c - "a" + 10;
                if (h < 16) wval = sat16(wval * 16 + h);
                else f &= ~SH_HEXTAIL;
            end
            if (!is_dig(c)) f &= ~SH_ALLDIG;
            else if ((f & SH_ALLDIG) != 0) wval = sat16(wval * 10 + (c - "0"));
        end
        f &= ~(SH_LASTOK | SH_COLON);
        if (is_word_char(c)) f |= SH_LASTOK;
        if (c == ":") f |= SH_COLON;
        for (int k = 0; k < 24; k++)
            if (idx >= kw_text[k].len() || kw_text[k][idx] != c) cand[k] = 1'b0;
        shape = f;
        wlen = idx < 15 ? idx + 1 : 15;
    endfunction

    function automatic int match_kw(int lo, int hi);
        for (int k = lo; k < hi; k++)
            if (cand[k] && kw_text[k].len() == wlen) return k;
        return -1;
    endfunction

    function automatic void note_token(bit [2:0] cls, int dir_id);
        if (ln_cnt == 0)
        begin
            if (cls == CL_DIR) ln_first = 3'(dir_id);
            else if (cls == CL_LABEL) ln_first = FIRST_LABEL;
            else if (cls == CL_NAME) ln_first = FIRST_NAME;
            else ln_first = FIRST_OTHER;
        end
        else
        begin
            if (ln_cnt == 1)
            begin
                ln_t1_cls = cls;
                ln_t1_below = (cls == CL_DEC || cls == CL_HEX) && wval < limit_reg;
            end
            else if (ln_cnt == 2)
                ln_t2_cls = cls;
            if (cls == CL_LABEL) ln_later_label = 1'b1;
        end
        if (ln_cnt < 7) ln_cnt++;
    endfunction

    function automatic lex_result_t end_word();
        lex_result_t r;
        bit [2:0] cls;
        int dir_id;
        bit ok;
        cls = CL_NAME;
        dir_id = 0;
        ok = 1'b1;
        if ((shape & SH_DOT) != 0)
        begin
            dir_id = match_kw(0, 5);
            cls = CL_DIR;
            ok = dir_id >= 0;
        end
        else if ((shape & SH_COLON) != 0)
        begin
            cls = CL_LABEL;
            ok = (shape & SH_DIG0) == 0 && (shape & SH_PREVOK) != 0;
        end
        else if ((shape & SH_HEXPRE) != 0)
        begin
            cls = CL_HEX;
            ok = (shape & SH_HEXTAIL) != 0;
        end
        else if ((shape & SH_ALLDIG) != 0)
            cls = CL_DEC;
        else if (match_kw(5, 24) >= 0)
            cls = CL_INS;
        else
            ok = (shape & SH_DIG0) == 0 && (shape & SH_PREVOK) != 0
                && (shape & SH_LASTOK) != 0;
        r = '{KIND_TOKEN, ok ? cls : CL_DIR, 16'(sat16(src_line)),
              ok ? ERR_NONE : ERR_LEX, 1'b0};
        if (ok) note_token(cls, dir_id);
        else stopped = 1'b1;
        wlen = 0; shape = 0; cand = 0; wval = 0;
        return r;
    endfunction

    function automatic bit num_cls(bit [2:0] c);
        return c == CL_DEC || c == CL_HEX;
    endfunction

    function automatic bit line_bad();
        bit t1dec;
        t1dec = ln_t1_cls == CL_DEC && ln_t1_below;
        if (ln_cnt == 0) return 1'b0;
        case (ln_first)
            3'd0: return ln_cnt != 3 || ln_t1_cls != CL_NAME || !num_cls(ln_t2_cls);
            3'd1: return ln_cnt != 2 || !ln_t1_below;
            3'd2: return ln_cnt != 2 || !t1dec;
            3'd3: return ln_cnt != 3 || !t1dec
                || !(num_cls(ln_t2_cls) || ln_t2_cls == CL_NAME);
            3'd4: return ln_cnt != 2 || !(num_cls(ln_t1_cls) || ln_t1_cls == CL_NAME);
            FIRST_LABEL: return ln_later_label;
            FIRST_NAME: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // works out the result items caused by one accepted byte
    function automatic void lex_byte(bit [7:0] raw);
        lex_result_t r[2];
        int n;
        bit eol, sep, bad;
        bit [7:0] c;
        if (stopped) return;
        c = (raw >= "A" && raw <= "Z") ? raw + 8'd32 : raw;
        eol = c == 8'h0a || c == 8'h00;
        sep = eol || c == " " || c == 8'h09;
        n = 0;
        if (scan == SCAN_NOTE)
        begin
            if (!eol) return;
        end
        else if (!sep)
        begin
            if (scan == SCAN_GAP && c == "#")
            begin
                scan = SCAN_NOTE;
                return;
            end
            take_char(c);
            scan = SCAN_WORD;
            return;
        end
        else if (scan == SCAN_WORD)
        begin
            r[0] = end_word();
            n = 1;
            scan = SCAN_GAP;
            if (stopped)
            begin
                r[0].last = 1'b1;
                pending_results.push_back(r[0]);
                return;
            end
        end
        if (eol)
        begin
            bad = line_bad();
            r[n] = '{KIND_VERDICT, CL_DIR, 16'(sat16(src_line)),
                     bad ? ERR_GRAM : ERR_NONE, 1'b0};
            n++;
            if (bad) stopped = 1'b1;
            clear_line();
            scan = SCAN_GAP;
            if (src_line < 65535) src_line++;
        end
        if (n > 0) r[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_results.push_back(r[i]);
    endfunction

    // ------------------------------------------------------------ driver
    bit [7:0]    text_fifo[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned bytes_taken = 0;
    int unsigned results_seen = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          long_hold_req = 1'b0;
    bit          hold_taken = 1'b0;
    int          hold_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                lex_byte(text_char);
                bytes_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (text_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    text_char <= text_fifo.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------ long hold-off
    // one long hold-off so the block backs up to its input
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_req && !hold_taken)
            begin
                hold_taken <= 1'b1;
                hold_left <= 400;
            end
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------ monitor
    always @(posedge clk)
    begin
        lex_result_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result item kind %0d line %0d", result_kind,
                        line_number);
                    error_count++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (result_kind !== e.kind)
                    begin
                        $error("result_kind exp %0d got %0d", e.kind, result_kind);
                        error_count++;
                    end
                    if (token_class !== e.cls)
                    begin
                        $error("token_class exp %0d got %0d", e.cls, token_class);
                        error_count++;
                    end
                    if (line_number !== e.line)
                    begin
                        $error("line_number exp %0d got %0d", e.line, line_number);
                        error_count++;
                    end
                    if (error_code !== e.err)
                    begin
                        $error("error_code exp %0d got %0d", e.err, error_code);
                        error_count++;
                    end
                    if (last !== e.last)
                    begin
                        $error("last exp %0d got %0d", e.last, last);
                        error_count++;
                    end
                end
            end
            if ((long_hold_req && !hold_taken) || hold_left > 0)
                out_stall <= 1'b1;
            else
                out_stall <= $urandom_range(99) < recv_stall_pct;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------ text generation
    function automatic void put_text(string s);
        bit [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(3) == 0) c -= 8'd32;
            text_fifo.push_back(c);
        end
    endfunction

    function automatic void put_gap();
        repeat ($urandom_range(1, 2))
            text_fifo.push_back($urandom_range(1) ? 8'h20 : 8'h09);
    endfunction

    function automatic string name_text();
        string lead, body, s;
        lead = "bcefghiknopqtuvwxyz_";
        body = "abcdefghijklmnopqrstuvwxyz0123456789_";
        s = "";
        s = {s, string'(lead[$urandom_range(lead.len() - 1)])};
        repeat ($urandom_range(9) == 0 ? $urandom_range(14, 22) : $urandom_range(0, 6))
            s = {s, string'(body[$urandom_range(body.len() - 1)])};
        return s;
    endfunction

    function automatic string num_text(int unsigned maxv, bit dec_only);
        int unsigned v;
        v = $urandom_range(maxv);
        if (!dec_only && $urandom_range(1))
            return $urandom_range(1) ? $sformatf("0x%0h", v) : $sformatf("0X%0H", v);
        return $urandom_range(7) == 0 ? $sformatf("00%0d", v) : $sformatf("%0d", v);
    endfunction

    function automatic string operand_text();
        case ($urandom_range(3))
            0: return name_text();
            1: return num_text($urandom_range(3) == 0 ? 99999 : 65535, 1'b0);
            2: return kw_text[$urandom_range(5, 23)];
            default: return num_text(300, 1'b0);
        endcase
    endfunction

    function automatic void put_note();
        bit [7:0] c;
        text_fifo.push_back("#");
        repeat ($urandom_range(0, 8))
        begin
            do c = $urandom_range(1, 255); while (c == 8'h0a);
            text_fifo.push_back(c);
        end
    endfunction

    // one correct line, content chosen at random
    function automatic void put_line(bit [15:0] lim);
        if ($urandom_range(3) == 0) put_gap();
        case ($urandom_range(11))
            0: ;
            1: put_note();
            2:
            begin
                put_text({name_text(), ":"});
                if ($urandom_range(1))
                begin
                    put_gap();
                    put_text(kw_text[$urandom_range(5, 23)]);
                end
            end
            3:
            begin
                put_text(".set"); put_gap(); put_text(name_text()); put_gap();
                put_text(num_text(65535, 1'b0));
            end
            4: begin put_text(".org"); put_gap(); put_text(num_text(lim - 1, 1'b0)); end
            5: begin put_text(".align"); put_gap(); put_text(num_text(lim - 1, 1'b1)); end
            6:
            begin
                put_text(".wfill"); put_gap(); put_text(num_text(lim - 1, 1'b1));
                put_gap();
                put_text($urandom_range(1) ? name_text() : num_text(65535, 1'b0));
            end
            7:
            begin
                put_text(".word"); put_gap();
                put_text($urandom_range(1) ? name_text() : num_text(65535, 1'b0));
            end
            default:
            begin
                put_text(kw_text[$urandom_range(5, 23)]);
                repeat ($urandom_range(3))
                begin
                    put_gap();
                    put_text(operand_text());
                end
            end
        endcase
        if ($urandom_range(4) == 0)
        begin
            put_gap();
            put_note();
        end
        else if ($urandom_range(5) == 0)
            put_gap();
        text_fifo.push_back($urandom_range(9) == 0 ? 8'h00 : 8'h0a);
    endfunction

    // ------------------------------------------------------------ sequencing
    task automatic wait_idle();
        wait (text_fifo.size() == 0 && !in_valid && pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(bit [15:0] v);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {16'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        limit_reg = v;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[15:0] !== v)
        begin
            $error("address_limit exp %0d got %0d", v, prdata[15:0]);
            error_count++;
        end
        psel <= 1'b0; penable <= 1'b0;
    endtask

    task automatic random_phase(bit [15:0] lim, int idle, int stall, int nbytes);
        write_limit(lim);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        while (text_fifo.size() < nbytes) put_line(lim);
    endtask

    initial
    begin
        limit_reg = ADDR_LIMIT_RESET;
        src_line = 1;
        scan = SCAN_GAP;
        stopped = 1'b0;
        wlen = 0; shape = 0; cand = 0; wval = 0;
        clear_line();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every keyword, field extremes, comments, zero byte end
        put_text(".set max 0xffff\n");
        put_text(".word 65535\t# \xff\x80 top bits\n");
        put_text("\n#only a note");
        text_fifo.push_back(8'h00);
        put_text("lbl_a: ld add sub mult div lsh rsh\n");
        put_text("ldinv ldabs ldmq ldmqmx store jump jumpl jumpr\n");
        put_text("addabs subabs storal storar 0x\n");
        put_text(".org 1023\n.align 0\n.wfill 7 0X1F\n");
        put_text("ld averyveryverylongoperandname 99999");
        text_fifo.push_back(8'h00);
        // odd bytes inside a note
        text_fifo.push_back("#");
        for (int b = 1; b < 256; b += 37) text_fifo.push_back(8'(b));
        text_fifo.push_back(8'h0a);
        wait_idle();

        random_phase(16'd1, 48, 0, 250);
        wait_idle();
        random_phase(16'd65535, 0, 48, 250);
        wait_idle();
        random_phase(16'($urandom_range(2, 65534)), 17, 17, 250);
        long_hold_req <= 1'b1;
        wait_idle();
        random_phase(16'($urandom_range(1, 64)), 0, 0, 250);
        wait_idle();

        // a faulty line halts the block, later bytes must be dropped
        random_phase(16'd1024, 17, 17, 100);
        if ($urandom_range(1)) put_text("ok_1 bad$word\n");
        else put_text("plainname 12\n");
        repeat (20) text_fifo.push_back($urandom_range(255));
        wait_idle();
        repeat (20) @(posedge clk);

        $display("covered %0d bytes over %0d lines, %0d result items checked",
            bytes_taken, src_line - 1, results_seen);
        $display("address_limit settings included 1 and 65535, run ended in halt");
        if (error_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/alc_pkg.sv
rtl/core/alc_front.sv
rtl/core/alc_back.sv
rtl/core/assembly_line_lexer_checker.sv
tb/tb_assembly_line_lexer_checker.sv
